// ----- hdl/escape_time_fractal_iterator_assert.svh -----
// Assertion macros for the escape-time fractal iterator.
// Used by the top level; no other dependencies.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ETFI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ETFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ETFI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define ETFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/etfi_pkg.sv -----
// Shared types, constants and helpers of the escape-time fractal iterator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package etfi_pkg;

    localparam int DEF_IMAGE_SIZE = 512;
    localparam int DEF_ITER_BITS  = 16;

    localparam int FRAC_BITS  = 28;
    localparam int WORD_W     = 32;
    localparam int RADIUS_W   = 31;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 48;
    localparam int SQ_W       = PROD_W - FRAC_BITS;
    localparam int CROSS_W    = PROD_W - FRAC_BITS + 1;
    localparam int MAG_W      = SQ_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int RADIUS_RESET   = 536870912;
    localparam int MAX_ITER_RESET = 400;

    localparam logic [MAG_W-1:0] ESCAPE_LIMIT = MAG_W'(64'd4 << FRAC_BITS);

    localparam logic KIND_JULIA      = 1'b0;
    localparam logic KIND_MANDELBROT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_VIEW_RADIUS  = 3'd2,
        CFG_PIXEL_STEP   = 3'd3,
        CFG_PERT_RE      = 3'd4,
        CFG_PERT_IM      = 3'd5,
        CFG_MAX_ITER     = 3'd6,
        CFG_FRACTAL_KIND = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] center_x;
        logic signed [WORD_W-1:0] center_y;
        logic [RADIUS_W-1:0]      view_radius;
        logic [RADIUS_W-1:0]      pixel_step;
        logic signed [WORD_W-1:0] pert_re;
        logic signed [WORD_W-1:0] pert_im;
        logic                     fractal_kind;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_ROW,
        MUL_COL,
        MUL_XX,
        MUL_YY,
        MUL_XY
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROW,
        ST_PCOL,
        ST_PFIN,
        ST_LOAD,
        ST_MXX,
        ST_MYY,
        ST_MXY,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     cap_pix;
        mul_sel_t mul_sel;
        logic     set_pa;
        logic     set_pb;
        logic     load_z;
        logic     cap_sx;
        logic     cap_sy;
        logic     update;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic escape;
    } dp_status_t;

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
        if (v > hi)
        begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/escape_time_fractal_iterator.sv -----
// Top level of the escape-time fractal iterator: register file, controller, datapath.
// Depends on etfi_pkg, etfi_cfg, etfi_ctrl, etfi_dp and the assertion macro header.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_we, cfg_index, cfg_data               | in
//  pixel   | in_valid, in_stall, col, row              | in
//  result  | out_valid, out_stall, pixel_col,          | out
//          | pixel_row, iter_count, bounded            |
//
// The block works on one pixel at a time, until that pixel's result is loaded.
// The multiply states MXX, MYY and MXY of each iteration come before the update state UPD,
// because one shared 32x32 multiplier forms x*x, y*y and x*y in turn.
// Reset is asynchronous and active low; no clearing pass is needed afterwards.
// A new pixel is taken while a finished result still waits in the result register;
// a stalled result only holds the controller once the next pixel is done.
`timescale 1ns / 1ps
`default_nettype none
`include "escape_time_fractal_iterator_assert.svh"

module escape_time_fractal_iterator
    import etfi_pkg::*;
#(
    parameter int IMAGE_SIZE = DEF_IMAGE_SIZE,
    parameter int ITER_BITS  = DEF_ITER_BITS,
    localparam int PIX_W     = $clog2(IMAGE_SIZE)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIX_W-1:0]      col,
    input  wire logic [PIX_W-1:0]      row,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PIX_W-1:0]           pixel_col,
    output logic [PIX_W-1:0]           pixel_row,
    output logic [ITER_BITS-1:0]       iter_count,
    output logic                       bounded
);

    cfg_t                 cfg;
    logic [ITER_BITS-1:0] max_iter;
    ctrl_cmd_t            cmd;
    dp_status_t           status;

    etfi_cfg #(
        .IMAGE_SIZE (IMAGE_SIZE),
        .ITER_BITS  (ITER_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .max_iter  (max_iter)
    );

    etfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    etfi_dp #(
        .PIX_W     (PIX_W),
        .ITER_BITS (ITER_BITS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .cfg        (cfg),
        .max_iter   (max_iter),
        .col        (col),
        .row        (row),
        .status     (status),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .iter_count (iter_count),
        .bounded    (bounded)
    );

    // A pixel transfer starts the setup sequence, so the next cycle is stalled.
    `ETFI_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall, "pixel accepted while busy")
    // The count starts at one and never wraps.
    `ETFI_ASSERT_NOW(a_count_nonzero, clk, rst_n, out_valid, iter_count != '0, "zero iteration count")
    // A freshly loaded result flags the limit exactly when the count reached it.
    `ETFI_ASSERT_NOW(a_bounded_match, clk, rst_n, $rose(out_valid), bounded == (iter_count >= $past(max_iter)), "bounded flag mismatch")

endmodule

`default_nettype wire

// ----- hdl/etfi_cfg.sv -----
// Configuration register file of the escape-time fractal iterator.
// Depends on etfi_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module etfi_cfg
    import etfi_pkg::*;
#(
    parameter int IMAGE_SIZE = DEF_IMAGE_SIZE,
    parameter int ITER_BITS  = DEF_ITER_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg,
    output logic [ITER_BITS-1:0]       max_iter
);

    localparam int STEP_RESET = (2 * RADIUS_RESET) / IMAGE_SIZE;

    cfg_t                 cfg_reg;
    logic [ITER_BITS-1:0] max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x     <= '0;
            cfg_reg.center_y     <= '0;
            cfg_reg.view_radius  <= RADIUS_W'(RADIUS_RESET);
            cfg_reg.pixel_step   <= RADIUS_W'(STEP_RESET);
            cfg_reg.pert_re      <= '0;
            cfg_reg.pert_im      <= '0;
            cfg_reg.fractal_kind <= KIND_MANDELBROT;
            max_iter_reg         <= ITER_BITS'(MAX_ITER_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X:     cfg_reg.center_x     <= cfg_data[WORD_W-1:0];
                CFG_CENTER_Y:     cfg_reg.center_y     <= cfg_data[WORD_W-1:0];
                CFG_VIEW_RADIUS:  cfg_reg.view_radius  <= cfg_data[RADIUS_W-1:0];
                CFG_PIXEL_STEP:   cfg_reg.pixel_step   <= cfg_data[RADIUS_W-1:0];
                CFG_PERT_RE:      cfg_reg.pert_re      <= cfg_data[WORD_W-1:0];
                CFG_PERT_IM:      cfg_reg.pert_im      <= cfg_data[WORD_W-1:0];
                CFG_MAX_ITER:     max_iter_reg         <= cfg_data[ITER_BITS-1:0];
                CFG_FRACTAL_KIND: cfg_reg.fractal_kind <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign cfg      = cfg_reg;
    assign max_iter = max_iter_reg;

endmodule

`default_nettype wire

// ----- hdl/etfi_dp.sv -----
// Datapath of the escape-time fractal iterator: one shared 32x32 multiplier,
// the point and iterate registers, the iteration counter and the result register.
// Depends on etfi_pkg; driven by commands from etfi_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module etfi_dp
    import etfi_pkg::*;
#(
    parameter int PIX_W     = 9,
    parameter int ITER_BITS = DEF_ITER_BITS
)
(
    input  wire logic                 clk,
    input  ctrl_cmd_t                 cmd,
    input  cfg_t                      cfg,
    input  wire logic [ITER_BITS-1:0] max_iter,
    input  wire logic [PIX_W-1:0]     col,
    input  wire logic [PIX_W-1:0]     row,
    output dp_status_t                status,
    output logic [PIX_W-1:0]          pixel_col,
    output logic [PIX_W-1:0]          pixel_row,
    output logic [ITER_BITS-1:0]      iter_count,
    output logic                      bounded
);

    logic [PIX_W-1:0]         pix_col_reg;
    logic [PIX_W-1:0]         pix_row_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-1:0]        prod_next;
    logic signed [WORD_W-1:0] pa_reg;
    logic signed [WORD_W-1:0] pb_reg;
    logic signed [WORD_W-1:0] zx_reg;
    logic signed [WORD_W-1:0] zy_reg;
    logic signed [WORD_W-1:0] cx_reg;
    logic signed [WORD_W-1:0] cy_reg;
    logic [SQ_W-1:0]          sx_reg;
    logic [SQ_W-1:0]          sy_reg;
    logic [ITER_BITS-1:0]     count_reg;
    logic [PIX_W-1:0]         out_col_reg;
    logic [PIX_W-1:0]         out_row_reg;
    logic [ITER_BITS-1:0]     out_count_reg;
    logic                     out_bounded_reg;

    logic [WORD_W-1:0]        op_a;
    logic [WORD_W-1:0]        op_b;
    logic [SUM_W-1:0]         pa_sum;
    logic [SUM_W-1:0]         pb_sum;
    logic [SUM_W-1:0]         nx_sum;
    logic [SUM_W-1:0]         ny_sum;
    logic [SQ_W-1:0]          sq_now;
    logic [CROSS_W-1:0]       cross_term;
    logic [MAG_W-1:0]         mag;

    always_comb
    begin
        op_a = {1'b0, cfg.pixel_step};
        op_b = {{(WORD_W-PIX_W){1'b0}}, pix_row_reg};
        case (cmd.mul_sel)
            MUL_ROW:
            begin
                op_a = {1'b0, cfg.pixel_step};
                op_b = {{(WORD_W-PIX_W){1'b0}}, pix_row_reg};
            end
            MUL_COL:
            begin
                op_a = {1'b0, cfg.pixel_step};
                op_b = {{(WORD_W-PIX_W){1'b0}}, pix_col_reg};
            end
            MUL_XX:
            begin
                op_a = zx_reg;
                op_b = zx_reg;
            end
            MUL_YY:
            begin
                op_a = zy_reg;
                op_b = zy_reg;
            end
            MUL_XY:
            begin
                op_a = zx_reg;
                op_b = zy_reg;
            end
            default:
            begin
                op_a = zx_reg;
                op_b = zy_reg;
            end
        endcase
    end

    // Both operands are sign extended, so the low 64 bits are the exact signed product.
    assign prod_next = {{(PROD_W-WORD_W){op_a[WORD_W-1]}}, op_a}
                     * {{(PROD_W-WORD_W){op_b[WORD_W-1]}}, op_b};

    // The step products are nonnegative and far below 2^47.
    assign pa_sum = {{(SUM_W-WORD_W){cfg.center_y[WORD_W-1]}}, cfg.center_y}
                  + {{(SUM_W-RADIUS_W){1'b0}}, cfg.view_radius}
                  - prod_reg[SUM_W-1:0];
    assign pb_sum = {{(SUM_W-WORD_W){cfg.center_x[WORD_W-1]}}, cfg.center_x}
                  - {{(SUM_W-RADIUS_W){1'b0}}, cfg.view_radius}
                  + prod_reg[SUM_W-1:0];

    // Arithmetic right shifts of the product give the floored fixed-point values.
    assign sq_now     = prod_reg[PROD_W-1:FRAC_BITS];
    assign cross_term = prod_reg[PROD_W-1:FRAC_BITS-1];

    // Squares are nonnegative, so the magnitude is an unsigned sum.
    assign mag = {1'b0, sx_reg} + {1'b0, sq_now};
    assign status.escape = (mag >= ESCAPE_LIMIT) || (count_reg >= max_iter);

    assign nx_sum = {{(SUM_W-SQ_W){sx_reg[SQ_W-1]}}, sx_reg}
                  - {{(SUM_W-SQ_W){sy_reg[SQ_W-1]}}, sy_reg}
                  + {{(SUM_W-WORD_W){cx_reg[WORD_W-1]}}, cx_reg};
    assign ny_sum = {{(SUM_W-CROSS_W){cross_term[CROSS_W-1]}}, cross_term}
                  + {{(SUM_W-WORD_W){cy_reg[WORD_W-1]}}, cy_reg};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.cap_pix)
        begin
            pix_col_reg <= col;
            pix_row_reg <= row;
        end
        if (cmd.set_pa)
        begin
            pa_reg <= sat32(pa_sum);
        end
        if (cmd.set_pb)
        begin
            pb_reg <= sat32(pb_sum);
        end
        if (cmd.load_z)
        begin
            count_reg <= {{(ITER_BITS-1){1'b0}}, 1'b1};
            if (cfg.fractal_kind == KIND_JULIA)
            begin
                zx_reg <= pa_reg;
                zy_reg <= pb_reg;
                cx_reg <= cfg.pert_re;
                cy_reg <= cfg.pert_im;
            end
            else
            begin
                zx_reg <= cfg.pert_re;
                zy_reg <= cfg.pert_im;
                cx_reg <= pa_reg;
                cy_reg <= pb_reg;
            end
        end
        else if (cmd.update)
        begin
            zx_reg    <= sat32(nx_sum);
            zy_reg    <= sat32(ny_sum);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.cap_sx)
        begin
            sx_reg <= sq_now;
        end
        if (cmd.cap_sy)
        begin
            sy_reg <= sq_now;
        end
        if (cmd.load_out)
        begin
            out_col_reg     <= pix_col_reg;
            out_row_reg     <= pix_row_reg;
            out_count_reg   <= count_reg;
            out_bounded_reg <= (count_reg >= max_iter);
        end
    end

    assign pixel_col  = out_col_reg;
    assign pixel_row  = out_row_reg;
    assign iter_count = out_count_reg;
    assign bounded    = out_bounded_reg;

endmodule

`default_nettype wire

// ----- hdl/etfi_ctrl.sv -----
// Controller of the escape-time fractal iterator: sequences the point setup,
// the three multiplies of each iteration and the hand-off to the result register.
// Depends on etfi_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module etfi_ctrl
    import etfi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The result register can be loaded when empty or when its transfer completes now.
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_PROW;
            ST_PROW: state_next = ST_PCOL;
            ST_PCOL: state_next = ST_PFIN;
            ST_PFIN: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_MXX;
            ST_MXX:  state_next = ST_MYY;
            ST_MYY:  state_next = ST_MXY;
            ST_MXY:  state_next = status.escape ? ST_DONE : ST_UPD;
            ST_UPD:  state_next = ST_MXX;
            ST_DONE: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MUL_XY;
        in_stall     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.cap_pix = in_valid;
            end
            ST_PROW: cmd.mul_sel = MUL_ROW;
            ST_PCOL:
            begin
                cmd.mul_sel = MUL_COL;
                cmd.set_pa  = 1'b1;
            end
            ST_PFIN: cmd.set_pb = 1'b1;
            ST_LOAD: cmd.load_z = 1'b1;
            ST_MXX:  cmd.mul_sel = MUL_XX;
            ST_MYY:
            begin
                cmd.mul_sel = MUL_YY;
                cmd.cap_sx  = 1'b1;
            end
            ST_MXY:
            begin
                cmd.mul_sel = MUL_XY;
                cmd.cap_sy  = 1'b1;
            end
            ST_UPD:  cmd.update = 1'b1;
            ST_DONE: cmd.load_out = slot_free;
            default: in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- test/escape_time_fractal_iterator_tb.sv -----
// Self-checking testbench for escape_time_fractal_iterator: a directed table, then random views.
// Each result is checked against a fixed-point escape-time predictor kept in this file or a value typed in the table.
// Depends on etfi_pkg and the escape_time_fractal_iterator RTL.
`timescale 1ns / 1ps

module escape_time_fractal_iterator_tb;
    import etfi_pkg::*;

    localparam int PIX_W        = $clog2(DEF_IMAGE_SIZE);
    localparam int ITER_W       = DEF_ITER_BITS;
    localparam int RANDOM_ITEMS = 1430;
    localparam int SCRIPT_LEN   = 36;
    // The longest transfer-free stretch is one pixel at the largest limit plus both stalls.
    localparam int QUIET_LIMIT  = 4 * (4 * 65535 + 5 + 2 * 8);

    localparam longint WORD_HI     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint WORD_LO     = -64'sh0000_0000_8000_0000;
    localparam longint ESCAPE_WIDE = longint'(ESCAPE_LIMIT);

    typedef struct packed {
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        logic [ITER_W-1:0] count;
        logic              bounded;
    } pixel_result_t;

    typedef struct {
        bit                is_write;
        cfg_idx_t          reg_idx;
        logic [31:0]       reg_data;
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        bit                typed;
        logic [ITER_W-1:0] count;
        logic              bounded;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      col = '0;
    logic [PIX_W-1:0]      row = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      pixel_col;
    logic [PIX_W-1:0]      pixel_row;
    logic [ITER_W-1:0]     iter_count;
    logic                  bounded;

    // Mirror of the register file, updated on every write.
    cfg_t              view;
    logic [ITER_W-1:0] iter_limit;

    pixel_result_t pending_counts[$];
    int            errors = 0;
    bit            idle_on = 1'b1;
    int unsigned   quiet_cycles = 0;

    script_row_t script [SCRIPT_LEN] = '{
        // Reset view: the center pixel sits at the origin, the corner escapes at once.
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd256, 9'd256, 1'b1, 16'd400, 1'b1},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd0, 9'd0, 1'b1, 16'd2, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd511, 9'd511, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd128, 9'd256, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd300, 9'd200, 1'b0, 16'd0, 1'b0},
        // Limits of zero and one stop before the first iteration.
        '{1'b1, CFG_MAX_ITER, 32'h0000_0000, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd256, 9'd256, 1'b1, 16'd1, 1'b1},
        '{1'b1, CFG_MAX_ITER, 32'h0000_0001, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd0, 9'd0, 1'b1, 16'd1, 1'b1},
        '{1'b1, CFG_MAX_ITER, 32'hFFFF_FFFF, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd256, 9'd256, 1'b1, 16'd65535, 1'b1},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd0, 9'd0, 1'b1, 16'd2, 1'b0},
        // Julia mode with a zero constant, upper data bits set to junk.
        '{1'b1, CFG_MAX_ITER, 32'hABCD_0064, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_FRACTAL_KIND, 32'hFFFF_FFFE, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd256, 9'd256, 1'b1, 16'd100, 1'b1},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd0, 9'd0, 1'b1, 16'd1, 1'b0},
        '{1'b1, CFG_PERT_RE, 32'hF333_3333, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_PERT_IM, 32'h027E_F9DB, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd200, 9'd300, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd256, 9'd100, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd400, 9'd400, 1'b0, 16'd0, 1'b0},
        // Extreme view: the pixel coordinates saturate in both directions.
        '{1'b1, CFG_CENTER_X, 32'h8000_0000, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_CENTER_Y, 32'h7FFF_FFFF, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_VIEW_RADIUS, 32'hFFFF_FFFF, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_PIXEL_STEP, 32'hFFFF_FFFF, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_PERT_RE, 32'h0000_0000, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_PERT_IM, 32'h0000_0000, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd0, 9'd0, 1'b1, 16'd1, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd511, 9'd511, 1'b1, 16'd1, 1'b0},
        // Mandelbrot from z = 1.5 with a saturated point: the first iterate saturates.
        '{1'b1, CFG_FRACTAL_KIND, 32'h0000_0001, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_PERT_RE, 32'h1800_0000, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd0, 9'd0, 1'b1, 16'd2, 1'b0},
        '{1'b1, CFG_PERT_RE, 32'h8000_0000, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd256, 9'd256, 1'b1, 16'd1, 1'b0},
        '{1'b1, CFG_PERT_RE, 32'h7FFF_FFFF, 9'd0, 9'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_CENTER_X, 32'h0, 9'd10, 9'd20, 1'b1, 16'd1, 1'b0}
    };

    escape_time_fractal_iterator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .col        (col),
        .row        (row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .iter_count (iter_count),
        .bounded    (bounded)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clamp32(longint v);
        if (v > WORD_HI)
        begin
            return WORD_HI;
        end
        if (v < WORD_LO)
        begin
            return WORD_LO;
        end
        return v;
    endfunction

    // Escape-time count of one pixel under the mirrored register settings.
    function automatic pixel_result_t escape_count(logic [PIX_W-1:0] c, logic [PIX_W-1:0] r);
        pixel_result_t res;
        longint        pa, pb, zx, zy, cx, cy, sx, sy, nx, ny;
        int unsigned   n;
        pa = clamp32(longint'($signed(view.center_y)) + longint'(view.view_radius)
                     - longint'(view.pixel_step) * longint'(r));
        pb = clamp32(longint'($signed(view.center_x)) - longint'(view.view_radius)
                     + longint'(view.pixel_step) * longint'(c));
        if (view.fractal_kind == KIND_JULIA)
        begin
            zx = pa;
            zy = pb;
            cx = longint'($signed(view.pert_re));
            cy = longint'($signed(view.pert_im));
        end
        else
        begin
            zx = longint'($signed(view.pert_re));
            zy = longint'($signed(view.pert_im));
            cx = pa;
            cy = pb;
        end
        n = 1;
        sx = (zx * zx) >>> FRAC_BITS;
        sy = (zy * zy) >>> FRAC_BITS;
        while (sx + sy < ESCAPE_WIDE && n < iter_limit)
        begin
            // The cross term 2*x*y is the product shifted by one bit less.
            ny = clamp32(((zx * zy) >>> (FRAC_BITS - 1)) + cy);
            nx = clamp32(sx - sy + cx);
            zx = nx;
            zy = ny;
            sx = (zx * zx) >>> FRAC_BITS;
            sy = (zy * zy) >>> FRAC_BITS;
            n++;
        end
        res.col     = c;
        res.row     = r;
        res.count   = n[ITER_W-1:0];
        res.bounded = (n >= iter_limit);
        return res;
    endfunction

    // Leaves cfg_we high; the caller lowers it after the last write of a batch.
    task automatic reg_write(cfg_idx_t idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_CENTER_X:     view.center_x = data;
            CFG_CENTER_Y:     view.center_y = data;
            CFG_VIEW_RADIUS:  view.view_radius = data[RADIUS_W-1:0];
            CFG_PIXEL_STEP:   view.pixel_step = data[RADIUS_W-1:0];
            CFG_PERT_RE:      view.pert_re = data;
            CFG_PERT_IM:      view.pert_im = data;
            CFG_MAX_ITER:     iter_limit = data[ITER_W-1:0];
            CFG_FRACTAL_KIND: view.fractal_kind = data[0];
            default:          ;
        endcase
    endtask

    // Presents one pixel and waits for its transfer; valid stays high when no gap follows.
    task automatic send_pixel(logic [PIX_W-1:0] c, logic [PIX_W-1:0] r, bit typed,
                              pixel_result_t typed_res);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        col      <= c;
        row      <= r;
        do @(posedge clk); while (in_stall);
        pending_counts.push_back(typed ? typed_res : escape_count(c, r));
    endtask

    task automatic wait_idle();
        while (pending_counts.size() != 0) @(posedge clk);
    endtask

    // Result side: random stall per result, then check each transfer in order.
    initial
    begin
        int unsigned   hold;
        pixel_result_t want;
        forever
        begin
            hold = idle_on ? $urandom_range(0, 8) : 0;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            if (pending_counts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result: col %0d row %0d count %0d bounded %0b",
                             pixel_col, pixel_row, iter_count, bounded);
                end
            end
            else
            begin
                want = pending_counts.pop_front();
                if (pixel_col !== want.col || pixel_row !== want.row
                    || iter_count !== want.count || bounded !== want.bounded)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: expected col %0d row %0d count %0d bounded %0b",
                                 want.col, want.row, want.count, want.bounded);
                        $display("          actual   col %0d row %0d count %0d bounded %0b",
                                 pixel_col, pixel_row, iter_count, bounded);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("escape_time_fractal_iterator_tb failed");
            $finish;
        end
    end

    initial
    begin
        pixel_result_t typed_res;
        logic [31:0]   vals [8];
        logic [31:0]   corner_vals [5];
        logic [31:0]   radius;
        logic          kind;
        logic [15:0]   limit;
        int            sent;
        int            batch;
        int            scenario;
        int            tail;
        bit            write_all;
        logic [PIX_W-1:0] c, r;

        corner_vals = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'hFFFF_FFFF};
        view.center_x     = '0;
        view.center_y     = '0;
        view.view_radius  = RADIUS_W'(RADIUS_RESET);
        view.pixel_step   = RADIUS_W'(2 * RADIUS_RESET / DEF_IMAGE_SIZE);
        view.pert_re      = '0;
        view.pert_im      = '0;
        view.fractal_kind = KIND_MANDELBROT;
        iter_limit        = ITER_W'(MAX_ITER_RESET);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                in_valid <= 1'b0;
                wait_idle();
                reg_write(script[i].reg_idx, script[i].reg_data);
            end
            else
            begin
                cfg_we <= 1'b0;
                typed_res = '{script[i].col, script[i].row, script[i].count, script[i].bounded};
                send_pixel(script[i].col, script[i].row, script[i].typed, typed_res);
            end
        end

        sent = 0;
        write_all = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            in_valid <= 1'b0;
            wait_idle();
            idle_on = ($urandom_range(0, 3) != 0);

            kind = 1'($urandom_range(0, 1));
            scenario = $urandom_range(0, 9);
            for (int k = 0; k < 8; k++)
            begin
                vals[k] = $urandom();
            end
            vals[CFG_FRACTAL_KIND] = {vals[CFG_FRACTAL_KIND][31:1], kind};
            if (scenario <= 4)
            begin
                // Classic view around the interesting region.
                radius = $urandom_range(32'h0100_0000, 32'h2000_0000);
                vals[CFG_CENTER_X]    = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                vals[CFG_CENTER_Y]    = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                vals[CFG_VIEW_RADIUS] = {vals[CFG_VIEW_RADIUS][31], radius[30:0]};
                vals[CFG_PIXEL_STEP]  = {vals[CFG_PIXEL_STEP][31], 8'd0, radius[30:8]};
                if (kind == KIND_JULIA)
                begin
                    vals[CFG_PERT_RE] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                    vals[CFG_PERT_IM] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                end
                else
                begin
                    vals[CFG_PERT_RE] = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                    vals[CFG_PERT_IM] = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                end
            end
            else if (scenario <= 6)
            begin
                // Deep zoom, step may round down to zero.
                radius = $urandom_range(1, 32'h0001_0000);
                vals[CFG_CENTER_X]    = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
                vals[CFG_CENTER_Y]    = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
                vals[CFG_VIEW_RADIUS] = radius;
                vals[CFG_PIXEL_STEP]  = radius >> 8;
                vals[CFG_PERT_RE]     = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                vals[CFG_PERT_IM]     = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            end
            else if (scenario == 9)
            begin
                for (int k = 0; k < 6; k++)
                begin
                    vals[k] = corner_vals[$urandom_range(0, 4)];
                end
            end

            case ($urandom_range(0, 19))
                0:       limit = 16'($urandom_range(0, 2));
                1, 2, 3: limit = 16'($urandom_range(129, 400));
                default: limit = 16'($urandom_range(3, 128));
            endcase
            vals[CFG_MAX_ITER] = {vals[CFG_MAX_ITER][31:16], limit};

            for (int k = 0; k < 8; k++)
            begin
                if (write_all || $urandom_range(0, 9) < 7)
                begin
                    reg_write(cfg_idx_t'(k), vals[k]);
                end
            end
            cfg_we <= 1'b0;
            write_all = 1'b0;

            batch = $urandom_range(15, 60);
            for (int j = 0; j < batch && sent < RANDOM_ITEMS; j++)
            begin
                c = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 9'd511 : 9'd0)
                                                : PIX_W'($urandom_range(0, 511));
                r = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 9'd511 : 9'd0)
                                                : PIX_W'($urandom_range(0, 511));
                send_pixel(c, r, 1'b0, '0);
                sent++;
            end
        end

        in_valid <= 1'b0;
        wait_idle();
        // Give a stray extra result time to show up.
        tail = 4 * int'(iter_limit) + 32;
        if (tail > 2000)
        begin
            tail = 2000;
        end
        repeat (tail) @(posedge clk);
        if (errors == 0)
        begin
            $display("escape_time_fractal_iterator_tb passed");
        end
        else
        begin
            $display("escape_time_fractal_iterator_tb failed");
        end
        $finish;
    end

endmodule
